>>> rtl/kti_pkg.sv
package kti_pkg;

   // Defaults for the top-level parameters
   localparam int ARROW_SLOTS_DEFAULT   = 16;
   localparam int KEYS_PER_SLOT_DEFAULT = 16;

   // Working slot register: holds any slot index up to 63 and the register value
   localparam int SLOT_REG_W = 6;
   localparam int USED_W     = 7;

   // Action codes
   localparam logic [1:0] ACT_SET    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_APPLY  = 2'd2;

   // Status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [7:0]         img;
   } point_type;

   typedef struct packed {
      logic [15:0] frame;
      point_type   from_pt;
      point_type   to_pt;
   } key_entry_type;

endpackage

>>> rtl/kti_ram.sv
module kti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/kti_lerp.sv
module kti_lerp (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] a,
   input  logic [15:0] b,
   input  logic [15:0] num,
   input  logic [15:0] den,
   output logic        done,
   output logic [15:0] result
);

   localparam logic [1:0] LS_IDLE = 2'd0;
   localparam logic [1:0] LS_MUL  = 2'd1;
   localparam logic [1:0] LS_DIV  = 2'd2;
   localparam logic [1:0] LS_FIN  = 2'd3;

   logic [1:0]  state_ff;
   logic        done_ff;
   logic [15:0] result_ff;
   logic [15:0] a_ff;
   logic        neg_ff;
   logic [15:0] mag_ff;
   logic [15:0] num_ff;
   logic [15:0] den_ff;
   logic [31:0] acc_ff;
   logic [15:0] rem_ff;
   logic [4:0]  cnt_ff;

   logic [16:0] diff;
   logic [16:0] mag_full;
   logic [16:0] trial;
   logic        fits;
   logic [16:0] trial_sub;
   logic [16:0] q_ext;
   logic [16:0] sum;

   // Difference and its magnitude
   always_comb begin
      diff     = {b[15], b} - {a[15], a};
      mag_full = diff[16] ? (~diff + 17'd1) : diff;
   end

   // One restoring division step: quotient bits shift into the accumulator
   always_comb begin
      trial     = {rem_ff, acc_ff[31]};
      fits      = trial >= {1'b0, den_ff};
      trial_sub = trial - {1'b0, den_ff};
   end

   // Apply the truncated quotient with the sign of the difference
   always_comb begin
      q_ext = {1'b0, acc_ff[15:0]};
      sum   = {a_ff[15], a_ff} + (neg_ff ? (~q_ext + 17'd1) : q_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            LS_IDLE: begin
               if (start) begin
                  a_ff     <= a;
                  neg_ff   <= diff[16];
                  mag_ff   <= mag_full[15:0];
                  num_ff   <= num;
                  den_ff   <= den;
                  state_ff <= LS_MUL;
               end
            end
            LS_MUL: begin
               acc_ff   <= 32'(mag_ff) * 32'(num_ff);
               rem_ff   <= '0;
               cnt_ff   <= 5'd31;
               state_ff <= LS_DIV;
            end
            LS_DIV: begin
               acc_ff <= {acc_ff[30:0], fits};
               rem_ff <= fits ? trial_sub[15:0] : trial[15:0];
               if (cnt_ff == 5'd0) begin
                  state_ff <= LS_FIN;
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
            LS_FIN: begin
               result_ff <= sum[15:0];
               done_ff   <= 1'b1;
               state_ff  <= LS_IDLE;
            end
            default: begin
               state_ff <= LS_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

>>> rtl/keyframe_track_interpolator_unit.sv
// Keyframe track interpolator.
// Input channel req_*: one transaction per command (set, remove, apply) with
// the keyframe fields. Output channel rsp_*: set, remove and unknown actions
// give one transaction; apply gives one per slot in use, in slot order, with
// rsp_last on the final one (none when no slot is in use). csr_wr_en writes
// the slots-in-use register; write it only while the block is idle.
// req_ready is high only when idle: one command is worked at a time.
// Keyframes sit in one single-port-write RAM with a registered read port.
// Set/remove scan the slot's keyframes, then shift keyframes to make or
// close a gap. Apply, per slot in use: scan the keyframes, then four
// interpolations on the shared multiply/divide unit (start, one multiply,
// 32 division steps, finish, handoff).
// Each result waits in the output register until rsp_ready; the sequencer
// holds meanwhile. Synchronous reset clears slot key counts, current poses
// and the register; keyframe RAM contents are left as they are, since only
// entries below a slot's key count are ever read.
module keyframe_track_interpolator_unit #(
   parameter int ARROW_SLOTS   = kti_pkg::ARROW_SLOTS_DEFAULT,
   parameter int KEYS_PER_SLOT = kti_pkg::KEYS_PER_SLOT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_slot,
   input  logic [15:0]        req_frame,
   input  logic signed [15:0] req_from_x,
   input  logic signed [15:0] req_from_y,
   input  logic [7:0]         req_from_image,
   input  logic signed [15:0] req_to_x,
   input  logic signed [15:0] req_to_y,
   input  logic [7:0]         req_to_image,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_status,
   output logic [3:0]         rsp_pose_slot,
   output logic signed [15:0] rsp_pose_from_x,
   output logic signed [15:0] rsp_pose_from_y,
   output logic [7:0]         rsp_pose_from_image,
   output logic signed [15:0] rsp_pose_to_x,
   output logic signed [15:0] rsp_pose_to_y,
   output logic [7:0]         rsp_pose_to_image,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [4:0]         csr_wr_data
);

   import kti_pkg::*;

   localparam int SI_W  = (ARROW_SLOTS > 1) ? $clog2(ARROW_SLOTS) : 1;
   localparam int IDX_W = $clog2(KEYS_PER_SLOT);
   localparam int CNT_W = $clog2(KEYS_PER_SLOT + 1);
   localparam int DEPTH = ARROW_SLOTS * KEYS_PER_SLOT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW    = $bits(key_entry_type);

   // Sequencer states
   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_START     = 5'd1;
   localparam logic [4:0] ST_FIND_RD   = 5'd2;
   localparam logic [4:0] ST_FIND_CHK  = 5'd3;
   localparam logic [4:0] ST_INS       = 5'd4;
   localparam logic [4:0] ST_SHUP_RD   = 5'd5;
   localparam logic [4:0] ST_SHUP_WR   = 5'd6;
   localparam logic [4:0] ST_PUT       = 5'd7;
   localparam logic [4:0] ST_SHDN_RD   = 5'd8;
   localparam logic [4:0] ST_SHDN_WR   = 5'd9;
   localparam logic [4:0] ST_SLOT      = 5'd10;
   localparam logic [4:0] ST_APP_RD    = 5'd11;
   localparam logic [4:0] ST_APP_CHK   = 5'd12;
   localparam logic [4:0] ST_LERP_GO   = 5'd13;
   localparam logic [4:0] ST_LERP_WAIT = 5'd14;
   localparam logic [4:0] ST_EMIT      = 5'd15;
   localparam logic [4:0] ST_OUT       = 5'd16;

   logic [4:0]            state_ff;
   logic [4:0]            aiu_ff;
   logic [1:0]            op_ff;
   logic [SLOT_REG_W-1:0] slot_ff;
   logic [15:0]           frame_ff;
   key_entry_type         new_ff;
   logic [CNT_W-1:0]      n_ff;
   logic [CNT_W-1:0]      idx_ff;
   logic [CNT_W-1:0]      pos_ff;
   logic                  grow_ff;
   logic                  status_ff;
   key_entry_type         lo_ff;
   key_entry_type         hi_ff;
   logic [1:0]            comp_ff;
   logic [15:0]           rx_ff [4];
   logic [CNT_W-1:0]      counts_ff [ARROW_SLOTS];
   point_type             pose_from_ff [ARROW_SLOTS];
   point_type             pose_to_ff [ARROW_SLOTS];

   logic                  rsp_valid_ff;
   logic                  rsp_status_ff;
   logic [3:0]            rsp_slot_ff;
   point_type             rsp_from_ff;
   point_type             rsp_to_ff;
   logic                  rsp_last_ff;

   logic [USED_W-1:0]     used;
   logic                  slot_ok;
   logic                  slot_live;
   logic [SI_W-1:0]       sidx;
   logic [CNT_W-1:0]      cur_n;
   logic [AW-1:0]         base;
   logic [CNT_W-1:0]      rd_idx;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic                  wr_en;
   key_entry_type         wr_data;
   key_entry_type         rd_data;
   logic [EW-1:0]         rd_bits;
   logic [15:0]           f_rd;

   logic                  lerp_start;
   logic [15:0]           lerp_a;
   logic [15:0]           lerp_b;
   logic [15:0]           lerp_num;
   logic [15:0]           lerp_den;
   logic                  lerp_done;
   logic [15:0]           lerp_res;

   // Slot bookkeeping
   always_comb begin
      used      = (USED_W'(aiu_ff) > USED_W'(ARROW_SLOTS)) ? USED_W'(ARROW_SLOTS)
                                                           : USED_W'(aiu_ff);
      slot_ok   = USED_W'(slot_ff) < USED_W'(ARROW_SLOTS);
      slot_live = USED_W'(slot_ff) < used;
      sidx      = slot_ff[SI_W-1:0];
      cur_n     = counts_ff[sidx];
      base      = AW'(sidx) * AW'(KEYS_PER_SLOT);
   end

   // Keyframe RAM addressing
   always_comb begin
      case (state_ff)
         ST_SHUP_RD: rd_idx = idx_ff - CNT_W'(1);
         ST_SHDN_RD: rd_idx = idx_ff + CNT_W'(1);
         default:    rd_idx = idx_ff;
      endcase
      rd_data = key_entry_type'(rd_bits);
      f_rd    = rd_data.frame;
      rd_addr = base + AW'(rd_idx[IDX_W-1:0]);
      wr_addr = base + AW'(idx_ff[IDX_W-1:0]);
      wr_en   = (state_ff == ST_SHUP_WR) || (state_ff == ST_SHDN_WR) || (state_ff == ST_PUT);
      wr_data = (state_ff == ST_PUT) ? new_ff : rd_data;
   end

   kti_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_keys (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_data)),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   // Operand select for the shared interpolation unit
   always_comb begin
      lerp_start = state_ff == ST_LERP_GO;
      lerp_num   = frame_ff - lo_ff.frame;
      lerp_den   = hi_ff.frame - lo_ff.frame;
      case (comp_ff)
         2'd0: begin
            lerp_a = lo_ff.from_pt.x;
            lerp_b = hi_ff.from_pt.x;
         end
         2'd1: begin
            lerp_a = lo_ff.from_pt.y;
            lerp_b = hi_ff.from_pt.y;
         end
         2'd2: begin
            lerp_a = lo_ff.to_pt.x;
            lerp_b = hi_ff.to_pt.x;
         end
         default: begin
            lerp_a = lo_ff.to_pt.y;
            lerp_b = hi_ff.to_pt.y;
         end
      endcase
   end

   kti_lerp u_lerp (
      .clock  (clock),
      .reset  (reset),
      .start  (lerp_start),
      .a      (lerp_a),
      .b      (lerp_b),
      .num    (lerp_num),
      .den    (lerp_den),
      .done   (lerp_done),
      .result (lerp_res)
   );

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         aiu_ff <= '0;
      end else if (csr_wr_en) begin
         aiu_ff <= csr_wr_data;
      end
   end

   // Command sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ARROW_SLOTS; i++) begin
            counts_ff[i]    <= '0;
            pose_from_ff[i] <= '0;
            pose_to_ff[i]   <= '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff          <= req_action;
                  slot_ff        <= (req_action == ACT_APPLY) ? '0 : SLOT_REG_W'(req_slot);
                  frame_ff       <= req_frame;
                  new_ff.frame   <= req_frame;
                  new_ff.from_pt <= '{x: req_from_x, y: req_from_y, img: req_from_image};
                  new_ff.to_pt   <= '{x: req_to_x, y: req_to_y, img: req_to_image};
                  status_ff      <= STATUS_FAIL;
                  state_ff       <= ST_START;
               end
            end
            ST_START: begin
               n_ff   <= cur_n;
               idx_ff <= '0;
               pos_ff <= '0;
               if (op_ff == ACT_APPLY) begin
                  state_ff <= ST_SLOT;
               end else if ((op_ff == ACT_SET || op_ff == ACT_REMOVE) && slot_live) begin
                  if (cur_n != '0) begin
                     state_ff <= ST_FIND_RD;
                  end else if (op_ff == ACT_SET) begin
                     state_ff <= ST_INS;
                  end else begin
                     state_ff <= ST_EMIT;
                  end
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_FIND_RD: begin
               state_ff <= ST_FIND_CHK;
            end
            ST_FIND_CHK: begin
               if (f_rd == frame_ff) begin
                  if (op_ff == ACT_SET) begin
                     grow_ff  <= 1'b0;
                     state_ff <= ST_PUT;
                  end else if (idx_ff + CNT_W'(1) >= n_ff) begin
                     counts_ff[sidx] <= n_ff - CNT_W'(1);
                     status_ff       <= STATUS_OK;
                     state_ff        <= ST_EMIT;
                  end else begin
                     state_ff <= ST_SHDN_RD;
                  end
               end else if (op_ff == ACT_SET && f_rd > frame_ff) begin
                  pos_ff   <= idx_ff;
                  state_ff <= ST_INS;
               end else if (idx_ff + CNT_W'(1) == n_ff) begin
                  pos_ff   <= n_ff;
                  state_ff <= (op_ff == ACT_SET) ? ST_INS : ST_EMIT;
               end else begin
                  idx_ff   <= idx_ff + CNT_W'(1);
                  state_ff <= ST_FIND_RD;
               end
            end
            ST_INS: begin
               // full list refuses a new frame
               if (n_ff >= CNT_W'(KEYS_PER_SLOT)) begin
                  state_ff <= ST_EMIT;
               end else begin
                  idx_ff   <= n_ff;
                  grow_ff  <= 1'b1;
                  state_ff <= (n_ff == pos_ff) ? ST_PUT : ST_SHUP_RD;
               end
            end
            ST_SHUP_RD: begin
               state_ff <= ST_SHUP_WR;
            end
            ST_SHUP_WR: begin
               idx_ff   <= idx_ff - CNT_W'(1);
               state_ff <= (idx_ff - CNT_W'(1) == pos_ff) ? ST_PUT : ST_SHUP_RD;
            end
            ST_PUT: begin
               if (grow_ff) begin
                  counts_ff[sidx] <= n_ff + CNT_W'(1);
               end
               pose_from_ff[sidx] <= new_ff.from_pt;
               pose_to_ff[sidx]   <= new_ff.to_pt;
               status_ff          <= STATUS_OK;
               state_ff           <= ST_EMIT;
            end
            ST_SHDN_RD: begin
               state_ff <= ST_SHDN_WR;
            end
            ST_SHDN_WR: begin
               idx_ff <= idx_ff + CNT_W'(1);
               if (idx_ff + CNT_W'(2) >= n_ff) begin
                  counts_ff[sidx] <= n_ff - CNT_W'(1);
                  status_ff       <= STATUS_OK;
                  state_ff        <= ST_EMIT;
               end else begin
                  state_ff <= ST_SHDN_RD;
               end
            end
            ST_SLOT: begin
               n_ff      <= cur_n;
               idx_ff    <= '0;
               status_ff <= STATUS_OK;
               if (!slot_live) begin
                  state_ff <= ST_IDLE;
               end else if (cur_n == '0) begin
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_APP_RD;
               end
            end
            ST_APP_RD: begin
               state_ff <= ST_APP_CHK;
            end
            ST_APP_CHK: begin
               // clamp at either end, else interpolate between prev and this key
               if ((idx_ff == '0 && frame_ff <= f_rd) ||
                   (idx_ff + CNT_W'(1) == n_ff && frame_ff >= f_rd)) begin
                  pose_from_ff[sidx] <= rd_data.from_pt;
                  pose_to_ff[sidx]   <= rd_data.to_pt;
                  state_ff           <= ST_EMIT;
               end else if (frame_ff <= f_rd) begin
                  hi_ff    <= rd_data;
                  comp_ff  <= 2'd0;
                  state_ff <= ST_LERP_GO;
               end else begin
                  lo_ff    <= rd_data;
                  idx_ff   <= idx_ff + CNT_W'(1);
                  state_ff <= ST_APP_RD;
               end
            end
            ST_LERP_GO: begin
               state_ff <= ST_LERP_WAIT;
            end
            ST_LERP_WAIT: begin
               if (lerp_done) begin
                  rx_ff[comp_ff] <= lerp_res;
                  if (comp_ff == 2'd3) begin
                     pose_from_ff[sidx] <= '{x: rx_ff[0], y: rx_ff[1], img: lo_ff.from_pt.img};
                     pose_to_ff[sidx]   <= '{x: rx_ff[2], y: lerp_res, img: lo_ff.to_pt.img};
                     state_ff           <= ST_EMIT;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= ST_LERP_GO;
                  end
               end
            end
            ST_EMIT: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= status_ff;
               rsp_slot_ff   <= slot_ff[3:0];
               rsp_from_ff   <= slot_ok ? pose_from_ff[sidx] : '0;
               rsp_to_ff     <= slot_ok ? pose_to_ff[sidx] : '0;
               rsp_last_ff   <= (op_ff != ACT_APPLY) ||
                                (USED_W'(slot_ff) + USED_W'(1) == used);
               state_ff      <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (op_ff == ACT_APPLY && !rsp_last_ff) begin
                     slot_ff  <= slot_ff + SLOT_REG_W'(1);
                     state_ff <= ST_SLOT;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Port drive
   assign req_ready           = state_ff == ST_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_pose_slot       = rsp_slot_ff;
   assign rsp_pose_from_x     = rsp_from_ff.x;
   assign rsp_pose_from_y     = rsp_from_ff.y;
   assign rsp_pose_from_image = rsp_from_ff.img;
   assign rsp_pose_to_x       = rsp_to_ff.x;
   assign rsp_pose_to_y       = rsp_to_ff.y;
   assign rsp_pose_to_image   = rsp_to_ff.img;
   assign rsp_last            = rsp_last_ff;

endmodule

>>> rtl/kti_checker.sv
module kti_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_status,
   input logic [3:0]         rsp_pose_slot,
   input logic signed [15:0] rsp_pose_from_x,
   input logic               rsp_last
);

   // Nothing is shown right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // One command at a time: never accepting while a result is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input ready while a result is pending");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pose_slot) &&
      $stable(rsp_pose_from_x) && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   // Accepted command keeps the block busy, with no result in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("block not busy after accepting a command");

   // More results of the same command follow before new input is taken
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("input taken in the middle of an apply burst");

endmodule

bind keyframe_track_interpolator_unit kti_checker u_kti_checker (.*);
